### rtl/core/ebts_pkg.sv
// Package for the EEPROM block transfer sequencer: request codes, bus command codes,
// session states, per-command and per-request plan types.
// No dependencies.
package ebts_pkg;

  localparam int PAGE_BYTES  = 128;  // power of two
  localparam int MAX_CMDS    = 5;
  localparam int CNT_W       = $clog2(MAX_CMDS + 1);
  localparam int IDX_W       = $clog2(MAX_CMDS);
  localparam int ADDR_W      = 16;
  localparam int DEV_W       = 7;

  localparam logic [ADDR_W-1:0] PAGE_MASK    = ADDR_W'(PAGE_BYTES - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST    = '1;
  localparam logic [DEV_W-1:0]  DEV_BASE_RST = 7'd80;
  localparam logic [DEV_W-1:0]  BANK_OFFSET  = 7'd4;

  localparam logic [2:0] ACT_BEGIN_WR = 3'd0;
  localparam logic [2:0] ACT_WRITE    = 3'd1;
  localparam logic [2:0] ACT_BEGIN_RD = 3'd2;
  localparam logic [2:0] ACT_READ     = 3'd3;
  localparam logic [2:0] ACT_END      = 3'd4;

  typedef enum logic [2:0] {
    CMD_START_WR       = 3'd0,
    CMD_WRITE          = 3'd1,
    CMD_READ_ACK       = 3'd2,
    CMD_READ_NACK_STOP = 3'd3,
    CMD_STOP           = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    SES_IDLE  = 2'd0,
    SES_WRITE = 2'd1,
    SES_READ  = 2'd2
  } session_e;

  typedef struct packed {
    cmd_e              command;
    logic [7:0]        bus_byte;
    logic              at_bank;
    logic [ADDR_W-1:0] at_address;
  } bus_cmd_t;

  typedef struct packed {
    bus_cmd_t [MAX_CMDS-1:0] cmds;
    logic [CNT_W-1:0]        count;
    logic                    bank_nxt;
    logic [ADDR_W-1:0]       address_nxt;
    session_e                session_nxt;
  } plan_t;

endpackage

### rtl/core/ebts_if.sv
// Request and bus command channel interfaces for the EEPROM block transfer sequencer.
// Depends on ebts_pkg for field widths.
interface ebts_req_if;
  import ebts_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic              bank;
  logic [ADDR_W-1:0] start_address;
  logic [7:0]        data_byte;
  logic              final_read;

  modport source (output valid, action, bank, start_address, data_byte, final_read,
                  input ready);
  modport sink (input valid, action, bank, start_address, data_byte, final_read,
                output ready);
endinterface

interface ebts_cmd_if;
  import ebts_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [7:0]        bus_byte;
  logic              at_bank;
  logic [ADDR_W-1:0] at_address;
  logic              run_end;

  modport source (output valid, command, bus_byte, at_bank, at_address, run_end,
                  input ready);
  modport sink (input valid, command, bus_byte, at_bank, at_address, run_end,
                output ready);
endinterface

### rtl/core/ebts_plan.sv
// Combinational planner: expands one request into its bus commands and next position/session.
// Depends on ebts_pkg.
module ebts_plan (
  input  logic [2:0]                  action,
  input  logic                        bank,
  input  logic [ebts_pkg::ADDR_W-1:0] start_address,
  input  logic [7:0]                  data_byte,
  input  logic                        final_read,
  input  logic                        cur_bank,
  input  logic [ebts_pkg::ADDR_W-1:0] cur_address,
  input  ebts_pkg::session_e          session,
  input  logic [ebts_pkg::DEV_W-1:0]  device_base,
  output ebts_pkg::plan_t             plan
);
  import ebts_pkg::*;

  function automatic logic [7:0] dev_byte(logic [DEV_W-1:0] base, logic bk, logic rd);
    logic [DEV_W-1:0] a;
    a = base + (bk ? BANK_OFFSET : '0);
    return {a, rd};
  endfunction

  function automatic bus_cmd_t mk(cmd_e c, logic [7:0] b, logic bk, logic [ADDR_W-1:0] ad);
    bus_cmd_t r;
    r.command    = c;
    r.bus_byte   = b;
    r.at_bank    = bk;
    r.at_address = ad;
    return r;
  endfunction

  logic              adv_bank;
  logic [ADDR_W-1:0] adv_addr;
  logic              page_end;

  assign adv_addr = cur_address + ADDR_W'(1);
  assign adv_bank = (cur_address == ADDR_LAST) ? ~cur_bank : cur_bank;
  assign page_end = (cur_address & PAGE_MASK) == PAGE_MASK;

  always_comb begin
    logic [IDX_W-1:0] off;
    off              = '0;
    plan.cmds        = '0;
    plan.count       = '0;
    plan.bank_nxt    = cur_bank;
    plan.address_nxt = cur_address;
    plan.session_nxt = session;
    case (action)
      ACT_BEGIN_WR, ACT_BEGIN_RD: begin
        if (session != SES_IDLE) begin
          plan.cmds[0] = mk(CMD_STOP, 8'h00, cur_bank, cur_address);
          off          = IDX_W'(1);
        end
        plan.cmds[off]              = mk(CMD_START_WR, dev_byte(device_base, bank, 1'b0),
                                         bank, start_address);
        plan.cmds[off + IDX_W'(1)]  = mk(CMD_WRITE, start_address[15:8], bank, start_address);
        plan.cmds[off + IDX_W'(2)]  = mk(CMD_WRITE, start_address[7:0], bank, start_address);
        plan.bank_nxt    = bank;
        plan.address_nxt = start_address;
        if (action == ACT_BEGIN_RD) begin
          plan.cmds[off + IDX_W'(3)] = mk(CMD_START_WR, dev_byte(device_base, bank, 1'b1),
                                          bank, start_address);
          plan.count       = CNT_W'(off) + CNT_W'(4);
          plan.session_nxt = SES_READ;
        end else begin
          plan.count       = CNT_W'(off) + CNT_W'(3);
          plan.session_nxt = SES_WRITE;
        end
      end
      ACT_WRITE: begin
        if (session == SES_WRITE) begin
          plan.cmds[0]     = mk(CMD_WRITE, data_byte, cur_bank, cur_address);
          plan.bank_nxt    = adv_bank;
          plan.address_nxt = adv_addr;
          if (page_end) begin
            plan.cmds[1] = mk(CMD_STOP, 8'h00, cur_bank, cur_address);
            plan.cmds[2] = mk(CMD_START_WR, dev_byte(device_base, adv_bank, 1'b0),
                              adv_bank, adv_addr);
            plan.cmds[3] = mk(CMD_WRITE, adv_addr[15:8], adv_bank, adv_addr);
            plan.cmds[4] = mk(CMD_WRITE, adv_addr[7:0], adv_bank, adv_addr);
            plan.count   = CNT_W'(5);
          end else begin
            plan.count   = CNT_W'(1);
          end
        end
      end
      ACT_READ: begin
        if (session == SES_READ) begin
          plan.bank_nxt    = adv_bank;
          plan.address_nxt = adv_addr;
          if (final_read) begin
            plan.cmds[0]     = mk(CMD_READ_NACK_STOP, 8'h00, cur_bank, cur_address);
            plan.count       = CNT_W'(1);
            plan.session_nxt = SES_IDLE;
          end else if (cur_address == ADDR_LAST) begin
            plan.cmds[0] = mk(CMD_READ_NACK_STOP, 8'h00, cur_bank, cur_address);
            plan.cmds[1] = mk(CMD_START_WR, dev_byte(device_base, adv_bank, 1'b0),
                              adv_bank, adv_addr);
            plan.cmds[2] = mk(CMD_WRITE, adv_addr[15:8], adv_bank, adv_addr);
            plan.cmds[3] = mk(CMD_WRITE, adv_addr[7:0], adv_bank, adv_addr);
            plan.cmds[4] = mk(CMD_START_WR, dev_byte(device_base, adv_bank, 1'b1),
                              adv_bank, adv_addr);
            plan.count   = CNT_W'(5);
          end else begin
            plan.cmds[0] = mk(CMD_READ_ACK, 8'h00, cur_bank, cur_address);
            plan.count   = CNT_W'(1);
          end
        end
      end
      ACT_END: begin
        plan.cmds[0]     = mk(CMD_STOP, 8'h00, cur_bank, cur_address);
        plan.count       = CNT_W'(1);
        plan.session_nxt = SES_IDLE;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/eeprom_block_transfer_sequencer_core.sv
// EEPROM block transfer sequencer top level: request channel, command buffer, state registers.
// Depends on ebts_pkg, ebts_if and ebts_plan.
//
// Usage:
//   in_req  carries block requests (begin write, write byte, begin read, read byte, end).
//   out_cmd carries byte-level I2C master commands, one per transfer, run_end set on the
//           last command of each request.
//   cfg_we/cfg_wdata write the 7-bit bank 0 device address; write only while idle.
// Each request is expanded in the accept cycle into 0 to 5 commands held in a command
// buffer. The first command is valid the cycle after accept; one command leaves per
// cycle that out_cmd.ready is high, in buffer order.
// The next request is accepted in the same cycle its predecessor's last command is taken,
// and not before, as all commands share the single output port.
// Requests producing no command leave the buffer empty, so in_req.ready stays high.
// A stalled receiver holds the current command and blocks new requests once the buffer
// is not draining. Reset empties the buffer, clears bank, address and session, and sets
// the device address to 0x50.
module eeprom_block_transfer_sequencer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  ebts_req_if.sink                   in_req,
  ebts_cmd_if.source                 out_cmd,
  input  logic                       cfg_we,
  input  logic [ebts_pkg::DEV_W-1:0] cfg_wdata
);
  import ebts_pkg::*;

  plan_t                   plan;
  bus_cmd_t [MAX_CMDS-1:0] cmds_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    bank_r;
  logic [ADDR_W-1:0]       address_r;
  session_e                session_r;
  logic [DEV_W-1:0]        dev_base_r;
  logic                    take;
  logic                    last;
  logic                    accept;
  bus_cmd_t                head;

  ebts_plan u_plan (
    .action        (in_req.action),
    .bank          (in_req.bank),
    .start_address (in_req.start_address),
    .data_byte     (in_req.data_byte),
    .final_read    (in_req.final_read),
    .cur_bank      (bank_r),
    .cur_address   (address_r),
    .session       (session_r),
    .device_base   (dev_base_r),
    .plan          (plan)
  );

  assign head   = cmds_r[idx_r];
  assign take   = out_cmd.valid && out_cmd.ready;
  assign last   = CNT_W'(idx_r) == (cnt_r - CNT_W'(1));
  assign in_req.ready = (cnt_r == '0) || (take && last);
  assign accept = in_req.valid && in_req.ready;

  assign out_cmd.valid      = cnt_r != '0;
  assign out_cmd.command    = head.command;
  assign out_cmd.bus_byte   = head.bus_byte;
  assign out_cmd.at_bank    = head.at_bank;
  assign out_cmd.at_address = head.at_address;
  assign out_cmd.run_end    = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      idx_r      <= '0;
      bank_r     <= 1'b0;
      address_r  <= '0;
      session_r  <= SES_IDLE;
      dev_base_r <= DEV_BASE_RST;
    end else begin
      if (cfg_we) begin
        dev_base_r <= cfg_wdata;
      end
      if (accept) begin
        cnt_r     <= plan.count;
        idx_r     <= '0;
        bank_r    <= plan.bank_nxt;
        address_r <= plan.address_nxt;
        session_r <= plan.session_nxt;
      end else if (take) begin
        if (last) begin
          cnt_r <= '0;
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmds_r <= plan.cmds;
    end
  end

endmodule
